@@ rtl/core/lcv_pkg.sv @@
// Package for the leaf class vote block: payload structs and default sizes.
// No dependencies.
package lcv_pkg;
	localparam int MAX_CLASSES_DEF = 16;
	localparam int COUNT_BITS_DEF = 32;
	localparam logic [1:0] FUNC_PRIOR = 2'd0;
	localparam logic [1:0] FUNC_LABEL = 2'd1;
	localparam logic [1:0] FUNC_FINISH = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [3:0] class_index;
		logic [15:0] prior_fraction;
	} lcv_in_t;

	typedef struct packed {
		logic [3:0] class_out;
		logic [16:0] hist_share;
		logic [31:0] reached_count;
		logic [3:0] major_label;
		logic major_valid;
		logic [3:0] second_label;
		logic second_valid;
		logic last;
	} lcv_out_t;
endpackage

@@ rtl/core/leaf_class_vote.sv @@
// Leaf class vote: label histogram, prior weighting and top-two scan.
// Depends on lcv_pkg. One shared serial divider serves all quotients.
// Loads and labels are accepted back to back while idle; the input stalls during a finish.
// Finish divides per class on the one-bit-per-cycle divider, DW = WBITS+log2(MAX_CLASSES)+18
// bits wide, and also waits on any output stall.
// Reset clears counts, total and sequencer and sets num_classes to 2; priors stay undefined.
module leaf_class_vote
	import lcv_pkg::*;
#(
	parameter int MAX_CLASSES = MAX_CLASSES_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input lcv_in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output lcv_out_t out_data,
	input logic cfg_we,
	input logic [4:0] cfg_wdata
);
	localparam int IW = $clog2(MAX_CLASSES);
	localparam int KW = $clog2(MAX_CLASSES + 1);
	localparam int WBITS = (COUNT_BITS + 16 < 56) ? COUNT_BITS + 16 : 56;
	localparam int SW = WBITS + IW + 1;
	localparam int DW = SW + 17;
	localparam int CW = $clog2(DW + 1);
	localparam logic [COUNT_BITS-1:0] CMAX = '1;
	localparam logic [WBITS-1:0] WCAP = '1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_WDIV = 3'd2;
	localparam logic [2:0] S_RDIV = 3'd3;
	localparam logic [2:0] S_SDIV = 3'd4;
	localparam logic [2:0] S_OUT = 3'd5;

	logic [COUNT_BITS-1:0] cnt_q [MAX_CLASSES];
	logic [15:0] prior_q [MAX_CLASSES];
	logic [COUNT_BITS-1:0] total_q;
	logic [4:0] ncls_q;
	logic [2:0] st_q;
	logic [IW-1:0] k_q;
	logic pass_q;
	logic [SW-1:0] sum_q;
	logic [WBITS-1:0] w_q;
	logic [COUNT_BITS-1:0] maxc_q, secc_q;
	logic [IW-1:0] maxk_q, seck_q;
	logic hsec_q;
	logic [DW-1:0] rem_q, quo_q, den_q;
	logic [CW-1:0] bit_q;
	logic [31:0] reach_q;
	logic [16:0] share_q;
	lcv_out_t out_q;
	logic ov_q;

	logic [KW-1:0] kk;
	always_comb begin
		if (ncls_q == 5'd0) kk = KW'(1);
		else if (32'(ncls_q) > 32'(MAX_CLASSES)) kk = KW'(MAX_CLASSES);
		else kk = KW'(ncls_q);
	end

	wire acc = in_valid && !in_stall;
	assign in_stall = st_q != S_IDLE;
	assign out_valid = ov_q;
	assign out_data = out_q;

	wire [IW-1:0] lidx = IW'(in_data.class_index);
	wire lbl_ok = (32'(in_data.class_index) < 32'(kk));
	wire [COUNT_BITS-1:0] ck = cnt_q[k_q];
	wire [15:0] pk = prior_q[k_q];
	wire is_last = (KW'(k_q) + KW'(1)) == kk;
	wire [DW-1:0] rsh = {rem_q[DW-2:0], quo_q[DW-1]};
	wire ge = rsh >= den_q;
	wire [DW-1:0] dnum = DW'({ck, 16'd0});
	wire [DW-1:0] wq = quo_q;
	wire wbig = wq > DW'(WCAP);
	wire valid = total_q != '0;
	wire out_load = (st_q == S_OUT) && (!ov_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ncls_q <= 5'd2;
			total_q <= '0;
			ov_q <= 1'b0;
			for (int i = 0; i < MAX_CLASSES; i++) cnt_q[i] <= '0;
		end else begin
			if (cfg_we) ncls_q <= cfg_wdata;
			if (out_load) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (acc) begin
						case (in_data.func)
							FUNC_PRIOR: begin
								if (32'(in_data.class_index) < 32'(MAX_CLASSES))
									prior_q[lidx] <= in_data.prior_fraction;
							end
							FUNC_LABEL: begin
								if (lbl_ok) begin
									if (cnt_q[lidx] != CMAX) cnt_q[lidx] <= cnt_q[lidx] + 1'b1;
									if (total_q != CMAX) total_q <= total_q + 1'b1;
								end
							end
							FUNC_FINISH: begin
								st_q <= S_SCAN;
								k_q <= '0;
								pass_q <= 1'b0;
								sum_q <= '0;
								hsec_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					if (!pass_q) begin
						if (k_q == '0 || ck > maxc_q) begin
							if (k_q != '0) begin
								secc_q <= maxc_q; seck_q <= maxk_q; hsec_q <= 1'b1;
							end
							maxc_q <= ck; maxk_q <= k_q;
						end else if (!hsec_q || ck > secc_q) begin
							secc_q <= ck; seck_q <= k_q; hsec_q <= 1'b1;
						end
					end
					if (pk == 16'd0) begin
						if (!pass_q) begin
							sum_q <= sum_q + SW'((ck != '0) ? WCAP : '0);
							if (is_last) begin pass_q <= 1'b1; k_q <= '0; end
							else k_q <= k_q + 1'b1;
						end else begin
							reach_q <= (ck != '0) ? '1 : '0;
							rem_q <= '0;
							quo_q <= (ck != '0) ? DW'({WCAP, 16'd0}) : '0;
							den_q <= DW'(sum_q);
							bit_q <= CW'(DW);
							st_q <= S_SDIV;
						end
					end else begin
						rem_q <= '0;
						quo_q <= dnum;
						den_q <= DW'(pk);
						bit_q <= CW'(DW);
						st_q <= S_WDIV;
					end
				end
				S_WDIV, S_RDIV, S_SDIV: begin
					if (bit_q != '0) begin
						rem_q <= ge ? rsh - den_q : rsh;
						quo_q <= {quo_q[DW-2:0], ge};
						bit_q <= bit_q - 1'b1;
					end else if (st_q == S_WDIV) begin
						w_q <= wbig ? WCAP : WBITS'(wq);
						if (!pass_q) begin
							sum_q <= sum_q + SW'(wbig ? WCAP : WBITS'(wq));
							st_q <= S_SCAN;
							if (is_last) begin pass_q <= 1'b1; k_q <= '0; end
							else k_q <= k_q + 1'b1;
						end else begin
							rem_q <= '0;
							quo_q <= wq;
							den_q <= DW'(kk);
							bit_q <= CW'(DW);
							st_q <= S_RDIV;
						end
					end else if (st_q == S_RDIV) begin
						reach_q <= (wq > DW'(32'hFFFF_FFFF)) ? '1 : wq[31:0];
						rem_q <= '0;
						quo_q <= DW'({w_q, 16'd0});
						den_q <= DW'(sum_q);
						bit_q <= CW'(DW);
						st_q <= S_SDIV;
					end else begin
						share_q <= (sum_q == '0) ? '0 : wq[16:0];
						st_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						out_q.class_out <= 4'(k_q);
						out_q.hist_share <= share_q;
						out_q.reached_count <= reach_q;
						out_q.major_label <= valid ? 4'(maxk_q) : 4'd0;
						out_q.major_valid <= valid;
						out_q.second_label <= (valid && hsec_q) ? 4'(seck_q) : 4'd0;
						out_q.second_valid <= valid && hsec_q;
						out_q.last <= is_last;
						if (is_last) begin
							st_q <= S_IDLE;
							total_q <= '0;
							for (int i = 0; i < MAX_CLASSES; i++) cnt_q[i] <= '0;
						end else begin
							k_q <= k_q + 1'b1;
							st_q <= S_SCAN;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> in_stall) else $error("accepting while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(out_data)) else $error("output changed under stall");
	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_OUT && is_last && !(ov_q && out_stall)) |=> (total_q == '0))
		else $error("counts not cleared");
`endif
endmodule
